FILE: rtl/dup_pkg.sv
// Shared types, codes and constant tables of the decimal unit value parser.
package dup_pkg;

    localparam int ACC_BITS_DEF = 40;
    localparam int VALUE_W      = 40;
    localparam int CHAR_W       = 8;
    localparam int UNITS_W      = 3;
    localparam int FRAC_W       = 5;

    localparam logic [FRAC_W-1:0] FRAC_MAX = 5'd31;
    localparam logic [63:0]       OUT_MAX  = 64'h0000_007F_FFFF_FFFF;

    localparam logic [UNITS_W-1:0] UNIT_INCH    = 3'd0;
    localparam logic [UNITS_W-1:0] UNIT_CM      = 3'd1;
    localparam logic [UNITS_W-1:0] UNIT_MM      = 3'd2;
    localparam logic [UNITS_W-1:0] UNIT_PICA    = 3'd3;
    localparam logic [UNITS_W-1:0] UNIT_CICERO  = 3'd4;
    localparam logic [UNITS_W-1:0] UNIT_POINT   = 3'd5;
    localparam logic [UNITS_W-1:0] UNIT_DIDOT   = 3'd6;
    localparam logic [UNITS_W-1:0] UNIT_PERCENT = 3'd7;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [CHAR_W-1:0] CH_LC_C    = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LC_D    = 8'h64;
    localparam logic [CHAR_W-1:0] CH_LC_M    = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_LC_P    = 8'h70;
    localparam logic [CHAR_W-1:0] CH_LC_T    = 8'h74;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_NUM,
        PH_SPACE,
        PH_SUFFIX2
    } phase_t;

    typedef enum logic [1:0] {
        SFX_C,
        SFX_M,
        SFX_P,
        SFX_D
    } sfx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNIT,
        ST_ALIGN,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic step;
        logic unit_mul;
        logic scale_up;
        logic div_init;
        logic div_step;
        logic load_out;
    } dup_cmd_t;

    typedef struct packed {
        logic tok_finish;
        logic need_up;
        logic need_down;
        logic div_done;
        logic out_free;
    } dup_sts_t;

    // decimals kept for each unit
    function automatic logic [FRAC_W-1:0] target_frac(input logic [UNITS_W-1:0] units);
        logic [FRAC_W-1:0] t;
        begin
            unique case (units)
                UNIT_INCH:        t = 5'd5;
                UNIT_CM, UNIT_MM: t = 5'd3;
                default:          t = 5'd2;
            endcase
            return t;
        end
    endfunction

    // powers of ten up to 10^18; all ones marks any larger power
    function automatic logic [63:0] pow10(input logic [FRAC_W-1:0] d);
        logic [63:0] p;
        begin
            unique case (d)
                5'd0:    p = 64'd1;
                5'd1:    p = 64'd10;
                5'd2:    p = 64'd100;
                5'd3:    p = 64'd1000;
                5'd4:    p = 64'd10000;
                5'd5:    p = 64'd100000;
                5'd6:    p = 64'd1000000;
                5'd7:    p = 64'd10000000;
                5'd8:    p = 64'd100000000;
                5'd9:    p = 64'd1000000000;
                5'd10:   p = 64'd10000000000;
                5'd11:   p = 64'd100000000000;
                5'd12:   p = 64'd1000000000000;
                5'd13:   p = 64'd10000000000000;
                5'd14:   p = 64'd100000000000000;
                5'd15:   p = 64'd1000000000000000;
                5'd16:   p = 64'd10000000000000000;
                5'd17:   p = 64'd100000000000000000;
                5'd18:   p = 64'd1000000000000000000;
                default: p = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
            return p;
        end
    endfunction

endpackage

FILE: rtl/dup_ctrl.sv
// Sequencing state machine of the decimal unit value parser.
module dup_ctrl import dup_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dup_sts_t  sts,
    output dup_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && sts.tok_finish) begin
                    state_next = ST_UNIT;
                end
            end
            ST_UNIT: begin
                state_next = ST_ALIGN;
            end
            ST_ALIGN: begin
                if (sts.need_down) begin
                    state_next = ST_DIV;
                end else if (!sts.need_up) begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        cmd.step     = (state_reg == ST_IDLE) && s_valid;
        cmd.unit_mul = (state_reg == ST_UNIT);
        cmd.scale_up = (state_reg == ST_ALIGN) && sts.need_up && !sts.need_down;
        cmd.div_init = (state_reg == ST_ALIGN) && sts.need_down;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.load_out = (state_reg == ST_EMIT) && sts.out_free;
    end

endmodule

FILE: rtl/dup_dp.sv
// Datapath: character decoding, accumulator, unit scaling, divider and output register.
module dup_dp import dup_pkg::*; #(
    parameter int ACC_BITS = ACC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [UNITS_W-1:0]         cfg_wdata,
    input  logic [CHAR_W-1:0]          s_char_code,
    input  logic                       s_end_of_input,
    input  dup_cmd_t                   cmd,
    output dup_sts_t                   sts,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [VALUE_W-1:0]  m_value,
    output logic [UNITS_W-1:0]         m_units,
    output logic                       m_pushback,
    output logic                       m_overflow
);

    localparam int MAG_W    = ACC_BITS - 1;
    localparam int PROD_W   = ACC_BITS + 3;
    localparam int CNT_W    = $clog2(MAG_W);
    localparam int DIV_LAST = MAG_W - 1;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // configuration
    logic [UNITS_W-1:0] dflt_units_reg;

    // token state
    phase_t             phase_reg, phase_next;
    logic [MAG_W-1:0]   acc_reg, acc_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic               point_reg, point_next;
    logic               neg_reg, neg_next;
    sfx_t               sfx_reg, sfx_next;
    logic               sat_reg, sat_next;

    // scaling state
    logic [MAG_W-1:0]   mag_reg;
    logic [FRAC_W-1:0]  sfc_reg;
    logic               ssat_reg;
    logic               sneg_reg;
    logic [UNITS_W-1:0] sunits_reg;
    logic               spush_reg;
    logic [MAG_W-1:0]   div_reg;
    logic [MAG_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // output register
    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [UNITS_W-1:0]        units_reg;
    logic                      push_reg;
    logic                      ovf_reg;

    // character decode
    logic               is_space;
    logic               is_num;
    logic [3:0]         digit;
    logic [PROD_W-1:0]  acc_prod;
    logic               acc_ovf;
    logic               do_num;
    logic               do_sfx;
    logic               fin;
    logic [UNITS_W-1:0] fin_units;
    logic               fin_push;

    // scaling
    logic [PROD_W-1:0]  p10;
    logic [PROD_W-1:0]  p12;
    logic               ov10;
    logic               ov12;
    logic [MAG_W-1:0]   r10;
    logic [MAG_W-1:0]   r12;
    logic [FRAC_W-1:0]  tgt;
    logic [FRAC_W-1:0]  drop;
    logic [63:0]        pw;
    logic               pw_big;
    logic [MAG_W:0]     trial;
    logic [MAG_W:0]     diff;
    logic               q_bit;
    logic [MAG_W-1:0]   fmag;
    logic [63:0]        fmag64;
    logic               oclamp;
    logic [VALUE_W-1:0] omag;

    assign is_space = (s_char_code == CH_SPACE) || (s_char_code == CH_TAB) ||
                      (s_char_code == CH_CR) || (s_char_code == CH_LF);
    assign is_num   = ((s_char_code >= CH_ZERO) && (s_char_code <= CH_NINE)) ||
                      (s_char_code == CH_MINUS) || (s_char_code == CH_POINT);
    assign digit    = 4'(s_char_code - CH_ZERO);

    assign acc_prod = (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1) + PROD_W'(digit);
    assign acc_ovf  = sat_reg || (|acc_prod[PROD_W-1:MAG_W]);

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        point_next = point_reg;
        neg_next   = neg_reg;
        sfx_next   = sfx_reg;
        sat_next   = sat_reg;
        fin        = 1'b0;
        fin_units  = dflt_units_reg;
        fin_push   = 1'b0;
        do_num     = 1'b0;
        do_sfx     = 1'b0;

        if (s_end_of_input) begin
            fin = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_NUM: begin
                    if (is_num) begin
                        do_num = 1'b1;
                    end else if (is_space) begin
                        phase_next = PH_SPACE;
                    end else begin
                        do_sfx = 1'b1;
                    end
                end
                PH_SPACE: begin
                    if (!is_space) begin
                        do_sfx = 1'b1;
                    end
                end
                PH_SUFFIX2: begin
                    fin      = 1'b1;
                    fin_push = 1'b1;
                    unique case (sfx_reg)
                        SFX_C: begin
                            if (s_char_code == CH_LC_M) begin
                                fin_units = UNIT_CM;
                                fin_push  = 1'b0;
                            end else if (s_char_code == CH_LC_C) begin
                                fin_units = UNIT_CICERO;
                                fin_push  = 1'b0;
                            end
                        end
                        SFX_M: begin
                            if (s_char_code == CH_LC_M) begin
                                fin_units = UNIT_MM;
                                fin_push  = 1'b0;
                            end
                        end
                        SFX_P: begin
                            if (s_char_code == CH_LC_C) begin
                                fin_units = UNIT_PICA;
                                fin_push  = 1'b0;
                            end else if (s_char_code == CH_LC_T) begin
                                fin_units = UNIT_POINT;
                                fin_push  = 1'b0;
                            end
                        end
                        SFX_D: begin
                            if (s_char_code == CH_LC_D) begin
                                fin_units = UNIT_DIDOT;
                                fin_push  = 1'b0;
                            end
                        end
                        default: begin
                            fin_push = 1'b1;
                        end
                    endcase
                end
                default: begin
                    if (is_num) begin
                        do_num = 1'b1;
                    end else if (!is_space) begin
                        do_sfx = 1'b1;
                    end
                end
            endcase
        end

        if (do_num) begin
            phase_next = PH_NUM;
            if (s_char_code == CH_MINUS) begin
                neg_next = 1'b1;
            end else if (s_char_code == CH_POINT) begin
                point_next = 1'b1;
                frac_next  = '0;
            end else begin
                acc_next = acc_ovf ? MAG_MAX : acc_prod[MAG_W-1:0];
                sat_next = acc_ovf;
                if (point_reg && (frac_reg != FRAC_MAX)) begin
                    frac_next = frac_reg + 1'b1;
                end
            end
        end

        if (do_sfx) begin
            priority if (s_char_code == CH_PERCENT) begin
                fin       = 1'b1;
                fin_units = UNIT_PERCENT;
            end else if (s_char_code == CH_QUOTE) begin
                fin       = 1'b1;
                fin_units = UNIT_INCH;
            end else if (s_char_code == CH_LC_C) begin
                sfx_next   = SFX_C;
                phase_next = PH_SUFFIX2;
            end else if (s_char_code == CH_LC_M) begin
                sfx_next   = SFX_M;
                phase_next = PH_SUFFIX2;
            end else if (s_char_code == CH_LC_P) begin
                sfx_next   = SFX_P;
                phase_next = PH_SUFFIX2;
            end else if (s_char_code == CH_LC_D) begin
                sfx_next   = SFX_D;
                phase_next = PH_SUFFIX2;
            end else begin
                fin      = 1'b1;
                fin_push = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_units_reg <= UNIT_INCH;
        end else if (cfg_we) begin
            dflt_units_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            acc_reg   <= '0;
            frac_reg  <= '0;
            point_reg <= 1'b0;
            neg_reg   <= 1'b0;
            sfx_reg   <= SFX_C;
            sat_reg   <= 1'b0;
        end else if (cmd.step) begin
            if (fin) begin
                phase_reg <= PH_LEAD;
                acc_reg   <= '0;
                frac_reg  <= '0;
                point_reg <= 1'b0;
                neg_reg   <= 1'b0;
                sfx_reg   <= SFX_C;
                sat_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                frac_reg  <= frac_next;
                point_reg <= point_next;
                neg_reg   <= neg_next;
                sfx_reg   <= sfx_next;
                sat_reg   <= sat_next;
            end
        end
    end

    assign p10  = (PROD_W'(mag_reg) << 3) + (PROD_W'(mag_reg) << 1);
    assign p12  = (PROD_W'(mag_reg) << 3) + (PROD_W'(mag_reg) << 2);
    assign ov10 = ssat_reg || (|p10[PROD_W-1:MAG_W]);
    assign ov12 = ssat_reg || (|p12[PROD_W-1:MAG_W]);
    assign r10  = ov10 ? MAG_MAX : p10[MAG_W-1:0];
    assign r12  = ov12 ? MAG_MAX : p12[MAG_W-1:0];

    assign tgt    = target_frac(sunits_reg);
    assign drop   = sfc_reg - tgt;
    assign pw     = pow10(drop);
    assign pw_big = |pw[63:MAG_W];

    assign trial = {rem_reg, mag_reg[MAG_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign q_bit = (trial >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        if (cmd.step && fin) begin
            mag_reg    <= acc_reg;
            sfc_reg    <= frac_reg;
            ssat_reg   <= sat_reg;
            sneg_reg   <= neg_reg;
            sunits_reg <= fin_units;
            spush_reg  <= fin_push;
        end else if (cmd.unit_mul) begin
            if ((sunits_reg == UNIT_PICA) || (sunits_reg == UNIT_CICERO)) begin
                mag_reg  <= r12;
                ssat_reg <= ov12;
            end else if (sunits_reg == UNIT_CM) begin
                mag_reg  <= r10;
                ssat_reg <= ov10;
            end
        end else if (cmd.scale_up) begin
            mag_reg  <= r10;
            ssat_reg <= ov10;
            sfc_reg  <= sfc_reg + 1'b1;
        end else if (cmd.div_init) begin
            div_reg <= pw_big ? MAG_MAX : pw[MAG_W-1:0];
            rem_reg <= '0;
            cnt_reg <= '0;
            sfc_reg <= tgt;
            if (pw_big) begin
                mag_reg <= '0;
            end
        end else if (cmd.div_step) begin
            mag_reg <= {mag_reg[MAG_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign fmag   = ssat_reg ? MAG_MAX : mag_reg;
    assign fmag64 = 64'(fmag);
    assign oclamp = (fmag64 > OUT_MAX);
    assign omag   = oclamp ? OUT_MAX[VALUE_W-1:0] : fmag64[VALUE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            value_reg <= sneg_reg ? $signed(~omag + 1'b1) : $signed(omag);
            units_reg <= sunits_reg;
            push_reg  <= spush_reg;
            ovf_reg   <= ssat_reg || oclamp;
        end
    end

    assign sts.tok_finish = fin;
    assign sts.need_up    = (sfc_reg < tgt);
    assign sts.need_down  = (sfc_reg > tgt);
    assign sts.div_done   = (cnt_reg == CNT_W'(DIV_LAST));
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_value    = value_reg;
    assign m_units    = units_reg;
    assign m_pushback = push_reg;
    assign m_overflow = ovf_reg;

endmodule

FILE: rtl/decimal_unit_value_parser.sv
// Top level of the decimal unit value parser: controller plus datapath.
// A character that does not end the token is taken back to back, with no stall.
// A token-ending item holds the input through the unit multiply, the decimal alignment
// (one decimal added per scale-up step, or decimals dropped by a bit-serial divide by a
// power of ten) and the emit, plus any wait for m_ready to free the output.
// aresetn (synchronous, active low) clears the parser state, the output valid and default units.
module decimal_unit_value_parser import dup_pkg::*; #(
    parameter int ACC_BITS = ACC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [UNITS_W-1:0]         cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CHAR_W-1:0]          s_char_code,
    input  logic                       s_end_of_input,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [VALUE_W-1:0]  m_value,
    output logic [UNITS_W-1:0]         m_units,
    output logic                       m_pushback,
    output logic                       m_overflow
);

    dup_cmd_t cmd;
    dup_sts_t sts;

    dup_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dup_dp #(
        .ACC_BITS (ACC_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_char_code    (s_char_code),
        .s_end_of_input (s_end_of_input),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_units        (m_units),
        .m_pushback     (m_pushback),
        .m_overflow     (m_overflow)
    );

endmodule
